@@ src/zmp_pkg.sv @@
package zmp_pkg;

    typedef enum logic [1:0] {
        OPN_BIND  = 2'd0,
        OPN_WRITE = 2'd1,
        OPN_QUERY = 2'd2,
        OPN_NONE  = 2'd3
    } t_opn;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED0_CTL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED0_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED1_CTL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRED1_VALUE = 3'd6;

    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_GT = 3'd1;
    localparam logic [2:0] CMP_GE = 3'd2;
    localparam logic [2:0] CMP_LT = 3'd3;
    localparam logic [2:0] CMP_LE = 3'd4;

    localparam int unsigned MAX_PREDS = 2;

    typedef enum logic [1:0] {
        PRE_SKIP,
        PRE_KEEP,
        PRE_CHECK
    } t_pre;

    typedef enum logic [1:0] {
        PS_CONT,
        PS_KEEP,
        PS_PRUNE
    } t_pstat;

    typedef struct packed {
        t_pre        pre;
        logic [2:0]  op;
        logic        vdbl;
        logic [63:0] value;
    } t_pred_req;

    typedef struct packed {
        logic        dbl;
        logic        nonempty;
        logic [63:0] maxv;
        logic [63:0] minv;
    } t_entry;

    typedef struct packed {
        t_pre        pre;
        logic [2:0]  op;
        logic        int_mode;
        logic        nonempty;
        logic [63:0] minv;
        logic [63:0] maxv;
        logic [63:0] value;
    } t_pred_ctl;

    typedef struct packed {
        logic query;
        logic keep_all;
    } t_meta;

    function automatic logic f_dnan(input logic [63:0] a);
        return (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    endfunction

    function automatic logic [63:0] f_dkey(input logic [63:0] a);
        return a[63] ? ~a : {1'b1, a[62:0]};
    endfunction

    function automatic logic f_dzeros(input logic [63:0] a, input logic [63:0] b);
        return (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    endfunction

    // ordered a < b, false on NaN, +0 and -0 equal
    function automatic logic f_dlt(input logic [63:0] a, input logic [63:0] b);
        return !f_dnan(a) && !f_dnan(b) && !f_dzeros(a, b) && (f_dkey(a) < f_dkey(b));
    endfunction

    function automatic logic f_deq(input logic [63:0] a, input logic [63:0] b);
        return !f_dnan(a) && !f_dnan(b) && ((a == b) || f_dzeros(a, b));
    endfunction

endpackage

@@ src/zmp_if.sv @@
interface zmp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [1:0]         slot;
    logic [15:0]        column_number;
    logic [8:0]         entry_count;
    logic [7:0]         entry_index;
    logic [31:0]        query_blk;
    logic signed [63:0] stat_min;
    logic signed [63:0] stat_max;
    logic               stat_nonempty;
    logic               stats_is_double;

    modport source (
        output valid, operation, slot, column_number, entry_count, entry_index,
               query_blk, stat_min, stat_max, stat_nonempty, stats_is_double,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, column_number, entry_count, entry_index,
               query_blk, stat_min, stat_max, stat_nonempty, stats_is_double,
        output ready
    );
endinterface

interface zmp_out_if;
    logic valid;
    logic ready;
    logic may_match;
    logic is_query_answer;

    modport source (output valid, may_match, is_query_answer, input ready);
    modport sink (input valid, may_match, is_query_answer, output ready);
endinterface

interface zmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ src/zmp_stats_mem.sv @@
module zmp_stats_mem #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10,
    parameter int unsigned PORTS = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  zmp_pkg::t_entry   i_wdata,
    input  logic [AW-1:0]     i_raddr [PORTS],
    output zmp_pkg::t_entry   o_rdata [PORTS]
);

    zmp_pkg::t_entry mem [DEPTH];
    zmp_pkg::t_entry r_rdata [PORTS];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    for (genvar p = 0; p < PORTS; p++) begin : g_rd
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rdata[p] <= mem[i_raddr[p]];
            end
        end
        assign o_rdata[p] = r_rdata[p];
    end

endmodule

@@ src/zmp_i2d.sv @@
// int64 to double, round to nearest even; double input passes through.
// Three register stages: magnitude, leading-zero count, shift and round.
module zmp_i2d (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_bits,
    input  logic        i_is_dbl,
    output logic [63:0] o_bits
);

    logic        r_a_sign, r_a_dbl;
    logic [63:0] r_a_mag;
    logic        r_b_sign, r_b_dbl;
    logic [63:0] r_b_mag;
    logic [5:0]  r_b_lz;
    logic [63:0] r_c_bits;

    logic [5:0]  n_lz;
    logic [63:0] norm;
    logic        rnd;
    logic [10:0] expo;
    logic [62:0] em;
    logic [63:0] n_c_bits;

    always_comb begin
        n_lz = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (r_a_mag[i]) begin
                n_lz = 6'(63 - i);
            end
        end
    end

    always_comb begin
        norm = r_b_mag << r_b_lz;
        rnd  = norm[10] && ((|norm[9:0]) || norm[11]);
        expo = 11'(11'd1086 - {5'd0, r_b_lz});
        em   = {expo, norm[62:11]} + 63'(rnd);
        if (r_b_dbl) begin
            n_c_bits = r_b_mag;
        end else if (r_b_mag == 64'd0) begin
            n_c_bits = 64'd0;
        end else begin
            n_c_bits = {r_b_sign, em};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dbl  <= i_is_dbl;
            r_a_sign <= i_bits[63] && !i_is_dbl;
            r_a_mag  <= (i_bits[63] && !i_is_dbl) ? (~i_bits + 64'd1) : i_bits;
            r_b_dbl  <= r_a_dbl;
            r_b_sign <= r_a_sign;
            r_b_mag  <= r_a_mag;
            r_b_lz   <= n_lz;
            r_c_bits <= n_c_bits;
        end
    end

    assign o_bits = r_c_bits;

endmodule

@@ src/zmp_pred_unit.sv @@
module zmp_pred_unit (
    input  logic                i_clk,
    input  logic                i_en,
    input  zmp_pkg::t_pred_req  i_req,
    input  zmp_pkg::t_entry     i_entry,
    output zmp_pkg::t_pstat     o_status
);

    logic [63:0]        w_min_d, w_max_d, w_val_d;
    zmp_pkg::t_pred_ctl n_ctl;
    zmp_pkg::t_pred_ctl r_ctl [3];
    zmp_pkg::t_pstat    n_status, r_status;
    logic               pass_i, pass_d, pass;

    zmp_i2d u_min (.i_clk, .i_en, .i_bits(i_entry.minv), .i_is_dbl(i_entry.dbl),
                   .o_bits(w_min_d));
    zmp_i2d u_max (.i_clk, .i_en, .i_bits(i_entry.maxv), .i_is_dbl(i_entry.dbl),
                   .o_bits(w_max_d));
    zmp_i2d u_val (.i_clk, .i_en, .i_bits(i_req.value), .i_is_dbl(i_req.vdbl),
                   .o_bits(w_val_d));

    always_comb begin
        n_ctl.pre      = i_req.pre;
        n_ctl.op       = i_req.op;
        n_ctl.int_mode = !i_entry.dbl && !i_req.vdbl;
        n_ctl.nonempty = i_entry.nonempty;
        n_ctl.minv     = i_entry.minv;
        n_ctl.maxv     = i_entry.maxv;
        n_ctl.value    = i_req.value;
    end

    always_comb begin
        case (r_ctl[2].op)
            zmp_pkg::CMP_EQ: pass_i = !(($signed(r_ctl[2].value) < $signed(r_ctl[2].minv)) ||
                                        ($signed(r_ctl[2].value) > $signed(r_ctl[2].maxv)));
            zmp_pkg::CMP_GT: pass_i = $signed(r_ctl[2].maxv) >  $signed(r_ctl[2].value);
            zmp_pkg::CMP_GE: pass_i = $signed(r_ctl[2].maxv) >= $signed(r_ctl[2].value);
            zmp_pkg::CMP_LT: pass_i = $signed(r_ctl[2].minv) <  $signed(r_ctl[2].value);
            zmp_pkg::CMP_LE: pass_i = $signed(r_ctl[2].minv) <= $signed(r_ctl[2].value);
            default:         pass_i = 1'b1;
        endcase
        case (r_ctl[2].op)
            zmp_pkg::CMP_EQ: pass_d = !(zmp_pkg::f_dlt(w_val_d, w_min_d) ||
                                        zmp_pkg::f_dlt(w_max_d, w_val_d));
            zmp_pkg::CMP_GT: pass_d = zmp_pkg::f_dlt(w_val_d, w_max_d);
            zmp_pkg::CMP_GE: pass_d = zmp_pkg::f_dlt(w_val_d, w_max_d) ||
                                      zmp_pkg::f_deq(w_max_d, w_val_d);
            zmp_pkg::CMP_LT: pass_d = zmp_pkg::f_dlt(w_min_d, w_val_d);
            zmp_pkg::CMP_LE: pass_d = zmp_pkg::f_dlt(w_min_d, w_val_d) ||
                                      zmp_pkg::f_deq(w_min_d, w_val_d);
            default:         pass_d = 1'b1;
        endcase
        pass = r_ctl[2].int_mode ? pass_i : pass_d;
    end

    always_comb begin
        case (r_ctl[2].pre)
            zmp_pkg::PRE_KEEP:  n_status = zmp_pkg::PS_KEEP;
            zmp_pkg::PRE_CHECK: n_status = (r_ctl[2].nonempty && pass) ? zmp_pkg::PS_CONT
                                                                       : zmp_pkg::PS_PRUNE;
            default:            n_status = zmp_pkg::PS_CONT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0] <= n_ctl;
            r_ctl[1] <= r_ctl[0];
            r_ctl[2] <= r_ctl[1];
            r_status <= n_status;
        end
    end

    assign o_status = r_status;

endmodule

@@ src/zone_map_block_pruner.sv @@
// Zone-map block pruner: one result per item, one item per cycle when the
// output is taken. Between input transfer and result valid lie the statistics
// memory read, three-stage int-to-double convert, compare and output register.
// A stalled output holds the whole pipeline.
// Synchronous active-low reset clears configuration, slot bindings and valids;
// statistics memory is not cleared.
module zone_map_block_pruner #(
    parameter int unsigned COLUMN_SLOTS     = 4,
    parameter int unsigned ENTRIES_PER_SLOT = 256,
    parameter int unsigned PREDICATES       = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    zmp_in_if.sink    i_in,
    zmp_out_if.source o_out,
    zmp_cfg_if.sink   i_cfg
);

    localparam int unsigned DEPTH = COLUMN_SLOTS * ENTRIES_PER_SLOT;
    localparam int unsigned MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned EIW   = (ENTRIES_PER_SLOT > 1) ? $clog2(ENTRIES_PER_SLOT) : 1;
    localparam int unsigned SW    = (COLUMN_SLOTS > 1) ? $clog2(COLUMN_SLOTS) : 1;
    localparam int unsigned LAT   = 5;

    logic        en;

    logic [31:0] r_first_block, r_block_count;
    logic [1:0]  r_pred_count;
    logic [19:0] r_pred_ctl [zmp_pkg::MAX_PREDS];
    logic [63:0] r_pred_val [zmp_pkg::MAX_PREDS];

    logic        r_slot_bound  [COLUMN_SLOTS];
    logic [15:0] r_slot_column [COLUMN_SLOTS];
    logic [8:0]  r_slot_length [COLUMN_SLOTS];

    logic [31:0]        rel;
    logic               keep_all;
    logic [1:0]         n_active;
    logic               found [PREDICATES];
    logic [SW-1:0]      fidx  [PREDICATES];
    logic [MAW-1:0]     raddr [PREDICATES];
    zmp_pkg::t_pred_req n_req [PREDICATES];
    zmp_pkg::t_pred_req r_req [PREDICATES];
    zmp_pkg::t_entry    rdata [PREDICATES];
    zmp_pkg::t_pstat    status [PREDICATES];

    logic               wr_en;
    logic [MAW-1:0]     waddr;
    zmp_pkg::t_entry    wdata;

    logic [LAT:1]       r_vld;
    zmp_pkg::t_meta     r_meta [LAT];
    zmp_pkg::t_meta     n_meta;

    logic               r_out_valid, r_out_match, r_out_query;
    logic               n_match, decided;

    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_block <= '0;
            r_block_count <= '0;
            r_pred_count  <= '0;
            for (int p = 0; p < zmp_pkg::MAX_PREDS; p++) begin
                r_pred_ctl[p] <= '0;
                r_pred_val[p] <= '0;
            end
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                zmp_pkg::CFG_FIRST_BLOCK: r_first_block <= i_cfg.data[31:0];
                zmp_pkg::CFG_BLOCK_COUNT: r_block_count <= i_cfg.data[31:0];
                zmp_pkg::CFG_PRED_COUNT:  r_pred_count  <= i_cfg.data[1:0];
                zmp_pkg::CFG_PRED0_CTL:   r_pred_ctl[0] <= i_cfg.data[19:0];
                zmp_pkg::CFG_PRED0_VALUE: r_pred_val[0] <= i_cfg.data;
                zmp_pkg::CFG_PRED1_CTL:   r_pred_ctl[1] <= i_cfg.data[19:0];
                zmp_pkg::CFG_PRED1_VALUE: r_pred_val[1] <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // slot bindings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < COLUMN_SLOTS; s++) begin
                r_slot_bound[s]  <= 1'b0;
                r_slot_column[s] <= '0;
                r_slot_length[s] <= '0;
            end
        end else if (i_in.valid && en && (i_in.operation == zmp_pkg::OPN_BIND) &&
                     (32'(i_in.slot) < COLUMN_SLOTS)) begin
            r_slot_bound[i_in.slot]  <= 1'b1;
            r_slot_column[i_in.slot] <= i_in.column_number;
            r_slot_length[i_in.slot] <= (32'(i_in.entry_count) > ENTRIES_PER_SLOT)
                                        ? 9'(ENTRIES_PER_SLOT) : i_in.entry_count;
        end
    end

    // entry write
    always_comb begin
        wr_en = i_in.valid && (i_in.operation == zmp_pkg::OPN_WRITE) &&
                (32'(i_in.slot) < COLUMN_SLOTS) && (32'(i_in.entry_index) < ENTRIES_PER_SLOT);
        waddr = MAW'(MAW'(i_in.slot) * MAW'(ENTRIES_PER_SLOT) + MAW'(i_in.entry_index));
        wdata.dbl      = i_in.stats_is_double;
        wdata.nonempty = i_in.stat_nonempty;
        wdata.maxv     = i_in.stat_max;
        wdata.minv     = i_in.stat_min;
    end

    // query front end: range check, slot lookup, memory address
    always_comb begin
        rel      = i_in.query_blk - r_first_block;
        keep_all = (i_in.query_blk < r_first_block) || (rel >= r_block_count);
        n_active = (32'(r_pred_count) > PREDICATES) ? 2'(PREDICATES) : r_pred_count;
        for (int p = 0; p < PREDICATES; p++) begin
            found[p] = 1'b0;
            fidx[p]  = '0;
            for (int s = COLUMN_SLOTS - 1; s >= 0; s--) begin
                if (r_slot_bound[s] && (r_slot_column[s] == r_pred_ctl[p][15:0])) begin
                    found[p] = 1'b1;
                    fidx[p]  = SW'(s);
                end
            end
            raddr[p] = MAW'(MAW'(fidx[p]) * MAW'(ENTRIES_PER_SLOT) + MAW'(rel[EIW-1:0]));
            n_req[p].op    = r_pred_ctl[p][18:16];
            n_req[p].vdbl  = r_pred_ctl[p][19];
            n_req[p].value = r_pred_val[p];
            if ((32'(p) >= 32'(n_active)) || !found[p]) begin
                n_req[p].pre = zmp_pkg::PRE_SKIP;
            end else if (rel >= {23'd0, r_slot_length[fidx[p]]}) begin
                n_req[p].pre = zmp_pkg::PRE_KEEP;
            end else begin
                n_req[p].pre = zmp_pkg::PRE_CHECK;
            end
        end
        n_meta.query    = (i_in.operation == zmp_pkg::OPN_QUERY);
        n_meta.keep_all = keep_all;
    end

    zmp_stats_mem #(.DEPTH(DEPTH), .AW(MAW), .PORTS(PREDICATES)) u_mem (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    for (genvar p = 0; p < PREDICATES; p++) begin : g_pred
        zmp_pred_unit u_pred (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_req    (r_req[p]),
            .i_entry  (rdata[p]),
            .o_status (status[p])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], i_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req     <= n_req;
            r_meta[0] <= n_meta;
            for (int k = 1; k < LAT; k++) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
    end

    // first predicate that keeps or prunes decides; out-of-range blocks are kept, non-queries never match
    always_comb begin
        n_match = 1'b1;
        decided = 1'b0;
        for (int p = 0; p < PREDICATES; p++) begin
            if (!decided && (status[p] != zmp_pkg::PS_CONT)) begin
                decided = 1'b1;
                n_match = (status[p] == zmp_pkg::PS_KEEP);
            end
        end
        if (r_meta[LAT-1].keep_all) begin
            n_match = 1'b1;
        end
        if (!r_meta[LAT-1].query) begin
            n_match = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[LAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_match <= n_match;
            r_out_query <= r_meta[LAT-1].query;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.may_match       = r_out_match;
    assign o_out.is_query_answer = r_out_query;

endmodule
